FILE: hdl/compacting_value_list_assert.svh
// Assertion macros shared by the compacting value list modules.
`ifndef COMPACTING_VALUE_LIST_ASSERT_SVH
`define COMPACTING_VALUE_LIST_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CVL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CVL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/cvl_pkg.sv
// Package: request and status codes and controller/datapath interface types.
`timescale 1ns / 1ps

package cvl_pkg;

	// Fixed field widths
	localparam int REQ_W  = 3;
	localparam int ITEM_W = 64;
	localparam int POS_W  = 6;
	localparam int ST_W   = 2;
	localparam int CNT_W  = 6;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_APPEND    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_REM_FIRST = 3'd1;
	localparam logic [REQ_W-1:0] REQ_REM_ALL   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_REPLACE   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_DUMP      = 3'd4;

	// Status codes
	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
	localparam logic [ST_W-1:0] ST_RANGE    = 2'd3;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;     // latch the request, clear scan pointers
		logic append;      // append value or flag full
		logic replace;     // overwrite indexed entry or flag range
		logic scan;        // one step of the compacting scan
		logic commit;      // take new length and status after scan
		logic dump_rd;     // read next entry for dump
		logic emit_final;  // load summary result into output register
		logic emit_elem;   // load dumped entry into output register
	} cvl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic             len_zero;
		logic             scan_done;
		logic             dump_last;
		logic             out_free;
	} cvl_sts_t;

endpackage

FILE: hdl/cvl_dp.sv
// Datapath: entry memory, length, scan pointers and the output register.
`timescale 1ns / 1ps
`include "compacting_value_list_assert.svh"

module cvl_dp
	import cvl_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [ITEM_W-1:0] item_value,
	input  logic [POS_W-1:0]  position,
	input  cvl_cmd_t          cmd,
	output cvl_sts_t          sts,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ST_W-1:0]   status,
	output logic [CNT_W-1:0]  list_length,
	output logic [CNT_W-1:0]  removed_count,
	output logic [ITEM_W-1:0] elem_value,
	output logic              elem_valid,
	output logic              last
);

	localparam int LEN_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
	localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(CAPACITY);

	// Entry store
	logic [ITEM_W-1:0] mem [CAPACITY];
	logic [ITEM_W-1:0] rdata_q;

	// Request registers
	logic [REQ_W-1:0]  req_q;
	logic [ITEM_W-1:0] val_q;
	logic [POS_W-1:0]  pos_q;
	logic [ST_W-1:0]   status_q;

	// List and scan state
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] rd_ptr_q;
	logic [LEN_W-1:0] wr_ptr_q;
	logic [LEN_W-1:0] rem_q;
	logic             hit_q;
	logic             rd_vld_s1;

	// Output register
	logic              out_valid_q;
	logic [ST_W-1:0]   o_status_q;
	logic [CNT_W-1:0]  o_len_q;
	logic [CNT_W-1:0]  o_rem_q;
	logic [ITEM_W-1:0] o_elem_q;
	logic              o_elem_vld_q;
	logic              o_last_q;

	logic                   full;
	logic                   pos_ok;
	logic                   rd_more;
	logic                   match;
	logic                   rd_en;
	logic                   we;
	logic [IDX_W-1:0]       wa;
	logic [ITEM_W-1:0]      wd;
	logic [LEN_W+CNT_W-1:0] len_ext;
	logic [LEN_W+CNT_W-1:0] rem_ext;
	logic [LEN_W:0]         scan_sum;

	// Decode of list conditions
	assign full    = (len_q == LEN_CAP);
	assign pos_ok  = ({{LEN_W{1'b0}}, pos_q} < {{CNT_W{1'b0}}, len_q});
	assign rd_more = (rd_ptr_q != len_q);
	assign match   = (rdata_q == val_q) && ((req_q == REQ_REM_ALL) || !hit_q);
	assign rd_en   = (cmd.scan && rd_more) || cmd.dump_rd;

	// Memory write port select
	always_comb begin
		we = 1'b0;
		wa = len_q[IDX_W-1:0];
		wd = val_q;
		if (cmd.append && !full) begin
			we = 1'b1;
		end else if (cmd.replace && pos_ok) begin
			we = 1'b1;
			wa = pos_q[IDX_W-1:0];
		end else if (cmd.scan && rd_vld_s1 && !match) begin
			we = 1'b1;
			wa = wr_ptr_q[IDX_W-1:0];
			wd = rdata_q;
		end
	end

	// Memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_ptr_q[IDX_W-1:0]];
		end
	end

	// Request and status registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q    <= req_type;
			val_q    <= item_value;
			pos_q    <= position;
			status_q <= ST_OK;
		end else if (cmd.append && full) begin
			status_q <= ST_FULL;
		end else if (cmd.replace && !pos_ok) begin
			status_q <= ST_RANGE;
		end else if (cmd.commit) begin
			status_q <= (rem_q == '0) ? ST_NOTFOUND : ST_OK;
		end
	end

	// Length and scan pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			rd_ptr_q  <= '0;
			wr_ptr_q  <= '0;
			rem_q     <= '0;
			hit_q     <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.capture) begin
				rd_ptr_q  <= '0;
				wr_ptr_q  <= '0;
				rem_q     <= '0;
				hit_q     <= 1'b0;
				rd_vld_s1 <= 1'b0;
			end else begin
				if (cmd.scan) begin
					rd_vld_s1 <= rd_more;
					if (rd_more) begin
						rd_ptr_q <= rd_ptr_q + LEN_ONE;
					end
					if (rd_vld_s1) begin
						if (match) begin
							rem_q <= rem_q + LEN_ONE;
							hit_q <= 1'b1;
						end else begin
							wr_ptr_q <= wr_ptr_q + LEN_ONE;
						end
					end
				end
				if (cmd.dump_rd) begin
					rd_ptr_q <= rd_ptr_q + LEN_ONE;
				end
			end
			if (cmd.append && !full) begin
				len_q <= len_q + LEN_ONE;
			end else if (cmd.commit) begin
				len_q <= wr_ptr_q;
			end
		end
	end

	assign len_ext = {{CNT_W{1'b0}}, len_q};
	assign rem_ext = {{CNT_W{1'b0}}, rem_q};

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_final || cmd.emit_elem) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit_final) begin
			o_status_q   <= status_q;
			o_len_q      <= len_ext[CNT_W-1:0];
			o_rem_q      <= rem_ext[CNT_W-1:0];
			o_elem_q     <= '0;
			o_elem_vld_q <= 1'b0;
			o_last_q     <= 1'b1;
		end else if (cmd.emit_elem) begin
			o_status_q   <= ST_OK;
			o_len_q      <= len_ext[CNT_W-1:0];
			o_rem_q      <= '0;
			o_elem_q     <= rdata_q;
			o_elem_vld_q <= 1'b1;
			o_last_q     <= !rd_more;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = o_status_q;
	assign list_length   = o_len_q;
	assign removed_count = o_rem_q;
	assign elem_value    = o_elem_q;
	assign elem_valid    = o_elem_vld_q;
	assign last          = o_last_q;

	// Status back to the controller
	assign sts.req       = req_q;
	assign sts.len_zero  = (len_q == '0);
	assign sts.scan_done = !rd_more && !rd_vld_s1;
	assign sts.dump_last = !rd_more;
	assign sts.out_free  = !out_valid_q || out_ready;

	assign scan_sum = {1'b0, rem_q} + {1'b0, wr_ptr_q} + {{LEN_W{1'b0}}, rd_vld_s1};

	`CVL_ASSERT_NOW(a_len_cap, 1'b1, len_q <= LEN_CAP, "length above capacity")
	`CVL_ASSERT_NOW(a_wr_behind, 1'b1, wr_ptr_q <= rd_ptr_q, "write pointer ahead of read")
	`CVL_ASSERT_NOW(a_scan_count, cmd.scan, scan_sum == {1'b0, rd_ptr_q},
		"kept plus removed entries do not match entries read")

endmodule

FILE: hdl/cvl_ctrl.sv
// Controller: request sequencing state machine for the compacting value list.
`timescale 1ns / 1ps
`include "compacting_value_list_assert.svh"

module cvl_ctrl
	import cvl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  cvl_sts_t sts,
	output cvl_cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE      = 6'b000001,
		S_DISPATCH  = 6'b000010,
		S_SCAN      = 6'b000100,
		S_DUMP_RD   = 6'b001000,
		S_DUMP_EMIT = 6'b010000,
		S_FINISH    = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (sts.req) inside
					REQ_APPEND: begin
						cmd.append = 1'b1;
						state_d    = S_FINISH;
					end
					REQ_REPLACE: begin
						cmd.replace = 1'b1;
						state_d     = S_FINISH;
					end
					REQ_REM_FIRST, REQ_REM_ALL: begin
						state_d = S_SCAN;
					end
					REQ_DUMP: begin
						state_d = sts.len_zero ? S_FINISH : S_DUMP_RD;
					end
					default: begin
						state_d = S_FINISH;
					end
				endcase
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					cmd.commit = 1'b1;
					state_d    = S_FINISH;
				end
			end
			S_DUMP_RD: begin
				cmd.dump_rd = 1'b1;
				state_d     = S_DUMP_EMIT;
			end
			S_DUMP_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_elem = 1'b1;
					state_d       = sts.dump_last ? S_IDLE : S_DUMP_RD;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.emit_final = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`CVL_ASSERT_NOW(a_emit_free, cmd.emit_final || cmd.emit_elem, sts.out_free,
		"result loaded while output register still occupied")
	`CVL_ASSERT_NOW(a_emit_one, 1'b1, !(cmd.emit_final && cmd.emit_elem),
		"two results loaded in one cycle")
	`CVL_ASSERT_NEXT(a_capture_dispatch, cmd.capture, !in_ready,
		"new request taken before the previous one was dispatched")

endmodule

FILE: hdl/compacting_value_list.sv
// Ordered list of 64-bit values with append, remove by value, replace and dump.
// Sequence: append, replace, unknown requests and an empty dump pass through the dispatch and
// finish states; remove-first and remove-all scan the whole list; dump reads each entry through
// the single registered read port of the entry memory, then emits it once the output is free.
// Throughput: one request in flight; the next is taken once the last result is registered.
// Reset: arst_n clears the length and control state; entry memory is not cleared.
`timescale 1ns / 1ps

module compacting_value_list
	import cvl_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [ITEM_W-1:0] item_value,
	input  logic [POS_W-1:0]  position,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ST_W-1:0]   status,
	output logic [CNT_W-1:0]  list_length,
	output logic [CNT_W-1:0]  removed_count,
	output logic [ITEM_W-1:0] elem_value,
	output logic              elem_valid,
	output logic              last
);

	cvl_cmd_t cmd;
	cvl_sts_t sts;

	// Request sequencer
	cvl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Storage, scan and result datapath
	cvl_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_type      (req_type),
		.item_value    (item_value),
		.position      (position),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.list_length   (list_length),
		.removed_count (removed_count),
		.elem_value    (elem_value),
		.elem_valid    (elem_valid),
		.last          (last)
	);

endmodule
